FILE: rtl/pabr_pkg.sv
package pabr_pkg;

   // Default sizes of the ring and of one packet fetch.
   localparam int DEPTH_DEFAULT     = 256;
   localparam int MAX_FETCH_DEFAULT = 64;

   // Entries in the command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Carriage return, the packet terminator.
   localparam logic [7:0] CR_BYTE = 8'h0D;

   localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

   // Opcodes of an input word.
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_GET  = 2'd2;

   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_POP,
      CMD_GET,
      CMD_NOP
   } cmd_kind_type;

   // One classified command as it travels from the front to the back.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [6:0]   limit;
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_PACKET
   } state_type;

endpackage

FILE: rtl/pabr_front.sv
module pabr_front #(
   parameter int MAX_FETCH = pabr_pkg::MAX_FETCH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_push_byte,
   input  logic [6:0]        req_fetch_limit,
   output logic              cmd_valid,
   output pabr_pkg::cmd_type cmd,
   input  logic              cmd_take
);

   localparam int QW = $clog2(pabr_pkg::QUEUE_DEPTH);
   localparam int FW = $clog2(pabr_pkg::QUEUE_DEPTH + 1);

   pabr_pkg::cmd_type queue_ff [pabr_pkg::QUEUE_DEPTH];
   pabr_pkg::cmd_type new_cmd;
   logic [QW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              push_q;
   logic              pop_q;

   // Classify the incoming word and clamp its fetch limit.
   always_comb begin
      case (req_opcode)
         pabr_pkg::OP_PUSH: new_cmd.kind = pabr_pkg::CMD_PUSH;
         pabr_pkg::OP_POP:  new_cmd.kind = pabr_pkg::CMD_POP;
         pabr_pkg::OP_GET:  new_cmd.kind = pabr_pkg::CMD_GET;
         default:           new_cmd.kind = pabr_pkg::CMD_NOP;
      endcase
      new_cmd.data = req_push_byte;
      if (32'(req_fetch_limit) > MAX_FETCH) begin
         new_cmd.limit = 7'(MAX_FETCH);
      end else begin
         new_cmd.limit = req_fetch_limit;
      end
   end

   assign req_ready = (fill_ff != FW'(pabr_pkg::QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push_q    = req_valid && req_ready;
   assign pop_q     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_q) begin
         wr_ptr_in = (wr_ptr_ff == QW'(pabr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_q) begin
         rd_ptr_in = (rd_ptr_ff == QW'(pabr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_q && !pop_q) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_q && !push_q) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: rtl/pabr_back.sv
module pabr_back #(
   parameter int DEPTH     = pabr_pkg::DEPTH_DEFAULT,
   parameter int MAX_FETCH = pabr_pkg::MAX_FETCH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  pabr_pkg::cmd_type cmd,
   output logic              cmd_take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last,
   output logic [7:0]        rsp_free_space,
   output logic [15:0]       rsp_packet_total,
   output logic              rsp_ring_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int RW = $clog2(MAX_FETCH + 1);

   pabr_pkg::state_type state_ff, state_in;

   logic [7:0]    store [DEPTH];
   logic [7:0]    rd_data_ff;
   logic          bypass_ff;
   logic [7:0]    bypass_data_ff;
   logic [7:0]    head;

   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rp_ff, rp_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [15:0]   pkt_ff, pkt_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic          we;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          byte_valid_ff, byte_valid_in;
   logic          last_ff, last_in;
   logic [7:0]    free_ff, free_in;
   logic [15:0]   total_ff, total_in;
   logic          empty_ff, empty_in;

   logic          out_free;
   logic          start;
   logic          get_go;
   logic [RW-1:0] step_rem;
   logic          step_last;
   logic [AW:0]   free_wide;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
      ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // The byte at the read pointer; a write to that same entry in the previous
   // cycle is forwarded because the array read returned the older contents.
   assign head = bypass_ff ? bypass_data_ff : rd_data_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign start     = (state_ff == pabr_pkg::ST_IDLE) && cmd_valid && out_free;
   assign get_go    = (cmd.kind == pabr_pkg::CMD_GET) && (pkt_ff != '0) &&
                      (cnt_ff != '0) && (cmd.limit != '0);
   assign step_rem  = (state_ff == pabr_pkg::ST_IDLE) ? RW'(cmd.limit) : rem_ff;
   assign step_last = (head == pabr_pkg::CR_BYTE) || (cnt_ff == AW'(1)) ||
                      (step_rem == RW'(1));
   assign cmd_take  = start;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pabr_pkg::ST_IDLE: begin
            if (start && get_go && !step_last) begin
               state_in = pabr_pkg::ST_PACKET;
            end
         end
         pabr_pkg::ST_PACKET: begin
            if (out_free && step_last) begin
               state_in = pabr_pkg::ST_IDLE;
            end
         end
         default: state_in = pabr_pkg::ST_IDLE;
      endcase
   end

   // Ring update and result word.
   always_comb begin
      logic       emit;
      logic       step;
      logic [7:0] e_byte;
      logic       e_valid;
      logic       e_last;

      emit    = 1'b0;
      step    = 1'b0;
      e_byte  = '0;
      e_valid = 1'b0;
      e_last  = 1'b1;
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      cnt_in  = cnt_ff;
      pkt_in  = pkt_ff;
      rem_in  = rem_ff;
      we      = 1'b0;

      case (state_ff)
         pabr_pkg::ST_IDLE: begin
            if (start) begin
               emit = 1'b1;
               case (cmd.kind)
                  pabr_pkg::CMD_PUSH: begin
                     we    = 1'b1;
                     wp_in = ring_next(wp_ff);
                     if (cnt_ff == AW'(DEPTH - 1)) begin
                        rp_in = ring_next(rp_ff);
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                     if (cmd.data == pabr_pkg::CR_BYTE && pkt_ff != pabr_pkg::COUNTER_MAX) begin
                        pkt_in = pkt_ff + 1'b1;
                     end
                  end
                  pabr_pkg::CMD_POP: begin
                     if (cnt_ff != '0) begin
                        e_byte  = head;
                        e_valid = 1'b1;
                        rp_in   = ring_next(rp_ff);
                        cnt_in  = cnt_ff - 1'b1;
                     end
                  end
                  pabr_pkg::CMD_GET: begin
                     step = get_go;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pabr_pkg::ST_PACKET: begin
            if (out_free) begin
               emit = 1'b1;
               step = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // One byte of a packet fetch.
      if (step) begin
         rp_in   = ring_next(rp_ff);
         cnt_in  = cnt_ff - 1'b1;
         rem_in  = step_rem - 1'b1;
         e_byte  = head;
         e_valid = 1'b1;
         e_last  = step_last;
         if (head == pabr_pkg::CR_BYTE) begin
            pkt_in = pkt_ff - 1'b1;
         end
      end

      free_wide = (AW + 1)'(DEPTH - 1) - {1'b0, cnt_in};

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      last_in       = last_ff;
      free_in       = free_ff;
      total_in      = total_ff;
      empty_in      = empty_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = e_byte;
         byte_valid_in = e_valid;
         last_in       = e_last;
         free_in       = (32'(free_wide) > 32'd255) ? 8'hFF : 8'(free_wide);
         total_in      = pkt_in;
         empty_in      = (cnt_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pabr_pkg::ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         pkt_ff       <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         pkt_ff       <= pkt_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
      free_ff       <= free_in;
      total_ff      <= total_in;
      empty_ff      <= empty_in;
   end

   // Byte store: one write port, one registered read at the next read pointer.
   always_ff @(posedge clock) begin
      if (we) begin
         store[wp_ff] <= cmd.data;
      end
      rd_data_ff     <= store[rp_in];
      bypass_ff      <= we && (wp_ff == rp_in);
      bypass_data_ff <= cmd.data;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_last         = last_ff;
   assign rsp_free_space   = free_ff;
   assign rsp_packet_total = total_ff;
   assign rsp_ring_empty   = empty_ff;

endmodule

FILE: rtl/packet_aware_byte_ring_unit.sv
// Packet-aware byte ring. Words arrive on the req_ channel (valid/ready) and
// carry an opcode: push a byte, pop a byte, or fetch one carriage-return
// terminated packet of at most req_fetch_limit bytes. The ring holds up to
// DEPTH-1 bytes; a push into a full ring drops the oldest byte.
// Results leave on the rsp_ channel (valid/ready), one word per push, pop,
// no-op or empty fetch, and one word per byte of a packet fetch, with
// rsp_last set on the final word that belongs to a request. Each result
// word also reports the free space (saturated at 255), the packet count and
// whether the ring is empty.
// A front stage classifies requests into a two-entry command queue, so
// req_ready stays high while the queue has room even if the result side is
// stalled. The back stage executes one command at a time; a packet fetch
// emits one byte per cycle while rsp_ready lets it, set by the single read
// port of the byte store, whose read of the next entry is registered.
// An accepted request passes the command queue and then the output register.
// When the receiver holds rsp_ready low, the output register holds its word
// and the back stage waits; the queue then fills and req_ready drops.
// Synchronous reset empties the ring, clears the packet count, the queue and
// the output valid flag; the byte store and the output data are not cleared.
module packet_aware_byte_ring_unit #(
   parameter int DEPTH     = pabr_pkg::DEPTH_DEFAULT,
   parameter int MAX_FETCH = pabr_pkg::MAX_FETCH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_push_byte,
   input  logic [6:0]  req_fetch_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [7:0]  rsp_free_space,
   output logic [15:0] rsp_packet_total,
   output logic        rsp_ring_empty
);

   // Command handoff between the front and back stages.
   logic              cmd_valid;
   logic              cmd_take;
   pabr_pkg::cmd_type cmd;

   pabr_front #(
      .MAX_FETCH (MAX_FETCH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_push_byte   (req_push_byte),
      .req_fetch_limit (req_fetch_limit),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take)
   );

   pabr_back #(
      .DEPTH     (DEPTH),
      .MAX_FETCH (MAX_FETCH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_free_space   (rsp_free_space),
      .rsp_packet_total (rsp_packet_total),
      .rsp_ring_empty   (rsp_ring_empty)
   );

endmodule

FILE: verif/ring_word_checker.sv
// Watches both channels of the byte ring, keeps its own copy of the ring and
// of the packet count, and checks every result word against the words that
// the accepted requests should have caused.
module ring_word_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_push_byte,
   input  logic [6:0]  req_fetch_limit,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_byte_valid,
   input  logic        rsp_last,
   input  logic [7:0]  rsp_free_space,
   input  logic [15:0] rsp_packet_total,
   input  logic        rsp_ring_empty,
   output int          fail_count,
   output int          rsp_words_pending,
   output int          words_checked,
   output int          ring_bytes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = pabr_pkg::DEPTH_DEFAULT;
   localparam int FETCH_CAP  = pabr_pkg::MAX_FETCH_DEFAULT;

   typedef struct {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last;
      logic [7:0]  free_space;
      logic [15:0] packet_total;
      logic        ring_empty;
   } rsp_word_type;

   logic [7:0]   ring_store [RING_DEPTH];
   int           wr_ptr;
   int           rd_ptr;
   logic [15:0]  packet_count;
   rsp_word_type rsp_words_due [$];
   int           mismatch_total;
   int           checked_total;
   int           bytes_total;

   function automatic int ring_next(input int p);
      return (p + 1) % RING_DEPTH;
   endfunction

   // Queues one expected word, with the status taken from the state as it is now.
   task automatic add_due_word(input logic [7:0] data, input logic valid, input logic last);
      rsp_word_type w;
      int           used;
      int           space;
      used           = (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
      space          = RING_DEPTH - 1 - used;
      w.out_byte     = data;
      w.byte_valid   = valid;
      w.last         = last;
      w.free_space   = (space > 255) ? 8'd255 : 8'(space);
      w.packet_total = packet_count;
      w.ring_empty   = (wr_ptr == rd_ptr);
      rsp_words_due.push_back(w);
   endtask

   task automatic predict_ring_words(input logic [1:0] op, input logic [7:0] data,
                                     input logic [6:0] lim);
      int         emitted;
      int         cap;
      logic [7:0] b;
      logic       stop;
      emitted = 0;
      if (op == pabr_pkg::OP_PUSH) begin
         ring_store[wr_ptr] = data;
         if (data == pabr_pkg::CR_BYTE && packet_count != pabr_pkg::COUNTER_MAX)
            packet_count++;
         wr_ptr = ring_next(wr_ptr);
         // A push into a full ring drops the oldest byte.
         if (wr_ptr == rd_ptr) rd_ptr = ring_next(rd_ptr);
         add_due_word(8'h00, 1'b0, 1'b1);
      end else if (op == pabr_pkg::OP_POP) begin
         if (wr_ptr == rd_ptr) begin
            add_due_word(8'h00, 1'b0, 1'b1);
         end else begin
            b      = ring_store[rd_ptr];
            rd_ptr = ring_next(rd_ptr);
            add_due_word(b, 1'b1, 1'b1);
         end
      end else begin
         if (op == pabr_pkg::OP_GET && packet_count != 16'd0) begin
            cap  = (int'(lim) > FETCH_CAP) ? FETCH_CAP : int'(lim);
            stop = 1'b0;
            while (!stop && wr_ptr != rd_ptr && emitted < cap) begin
               b      = ring_store[rd_ptr];
               rd_ptr = ring_next(rd_ptr);
               if (b == pabr_pkg::CR_BYTE) packet_count--;
               stop = (b == pabr_pkg::CR_BYTE) || (wr_ptr == rd_ptr) ||
                      (emitted + 1 >= cap);
               add_due_word(b, 1'b1, stop);
               emitted++;
            end
         end
         if (emitted == 0) add_due_word(8'h00, 1'b0, 1'b1);
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_total++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s got %0h expected %0h",
                                   checked_total, name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         wr_ptr       = 0;
         rd_ptr       = 0;
         packet_count = '0;
         rsp_words_due.delete();
      end else begin
         // Results are compared before the new request is predicted, since a
         // result accepted at this edge always belongs to an earlier request.
         if (rsp_valid && rsp_ready) begin
            if (rsp_words_due.size() == 0) begin
               report_mismatch($sformatf("result word %0d with nothing expected, byte %0h",
                                         checked_total, rsp_out_byte));
            end else begin
               want = rsp_words_due.pop_front();
               check_field("out_byte", 16'(rsp_out_byte), 16'(want.out_byte));
               check_field("byte_valid", 16'(rsp_byte_valid), 16'(want.byte_valid));
               check_field("last", 16'(rsp_last), 16'(want.last));
               check_field("free_space", 16'(rsp_free_space), 16'(want.free_space));
               check_field("packet_total", rsp_packet_total, want.packet_total);
               check_field("ring_empty", 16'(rsp_ring_empty), 16'(want.ring_empty));
               if (want.byte_valid) bytes_total++;
            end
            checked_total++;
         end
         if (req_valid && req_ready)
            predict_ring_words(req_opcode, req_push_byte, req_fetch_limit);
      end
      rsp_words_pending <= rsp_words_due.size();
      fail_count        <= mismatch_total;
      words_checked     <= checked_total;
      ring_bytes_seen   <= bytes_total;
   end

endmodule

FILE: verif/tb_packet_aware_byte_ring_unit.sv
// Top of the byte ring testbench. It makes the clock and the single reset,
// drives request words, plays the receiver, and gives the verdict. All
// prediction and comparison lives in the checker instantiated beside the block.
module tb_packet_aware_byte_ring_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam time CLK_PERIOD      = 10ns;
   localparam int  RESET_CYCLES    = 8;
   localparam int  IDLE_PERCENT    = 18;
   localparam int  RSP_HOLD_CYCLES = 120;
   localparam int  STALL_LIMIT     = 2000;
   localparam int  SETTLE_CYCLES   = 20;
   localparam int  RANDOM_ITEMS    = 100;
   localparam int  FILL_ITEMS      = 40;

   // The package names the three real opcodes; the fourth code is unused and
   // the block must treat it as a no-op that still answers with a status word.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode      = pabr_pkg::OP_PUSH;
   logic [7:0]  req_push_byte   = 8'h00;
   logic [6:0]  req_fetch_limit = 7'd1;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_last;
   logic [7:0]  rsp_free_space;
   logic [15:0] rsp_packet_total;
   logic        rsp_ring_empty;

   int   fail_count;
   int   rsp_words_pending;
   int   words_checked;
   int   ring_bytes_seen;

   // While steady_flow is set, neither side idles.
   logic steady_flow   = 1'b0;
   // The stimulus asks the receiver for a long hold-off by raising
   // hold_requests; the receiver counts the ones it has served.
   int   hold_requests = 0;
   int   holds_done    = 0;
   int   op_tally [4]  = '{default: 0};
   int   stall_cycles  = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   packet_aware_byte_ring_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_push_byte    (req_push_byte),
      .req_fetch_limit  (req_fetch_limit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_free_space   (rsp_free_space),
      .rsp_packet_total (rsp_packet_total),
      .rsp_ring_empty   (rsp_ring_empty)
   );

   ring_word_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_push_byte     (req_push_byte),
      .req_fetch_limit   (req_fetch_limit),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last          (rsp_last),
      .rsp_free_space    (rsp_free_space),
      .rsp_packet_total  (rsp_packet_total),
      .rsp_ring_empty    (rsp_ring_empty),
      .fail_count        (fail_count),
      .rsp_words_pending (rsp_words_pending),
      .words_checked     (words_checked),
      .ring_bytes_seen   (ring_bytes_seen)
   );

   // The watchdog counts cycles in which no word moves on either channel. The
   // longest honest gap is the receiver hold-off, well below the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles with no word accepted", stall_cycles);
         $display("tb_packet_aware_byte_ring_unit NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Receiver. It is ready most of the time, idles now and then, and on request
   // holds rsp_ready low for a long stretch so that the command queue fills and
   // the block has to drop req_ready.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Offers one request word and returns at the edge where it is accepted.
   // Valid stays high on return, so a word that follows directly costs no gap;
   // an idle gap lowers valid first and raises it again at a later edge.
   task automatic send_word(input logic [1:0] op, input logic [7:0] data,
                            input logic [6:0] lim);
      if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_push_byte   <= data;
      req_fetch_limit <= lim;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      op_tally[op]++;
   endtask

   // Stops offering and waits until every expected result word has come. The
   // first edge lets the checker take in the word accepted just now.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_words_pending != 0) @(posedge clock);
   endtask

   // Mostly legal limits, some tiny ones to cut packets short, and now and then
   // zero or a value above the fetch cap, which the block clamps.
   function automatic logic [6:0] pick_limit();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 7'($urandom_range(pabr_pkg::MAX_FETCH_DEFAULT, 1));
      if (r < 85) return 7'($urandom_range(4, 1));
      if (r < 95) return 7'($urandom_range(127, pabr_pkg::MAX_FETCH_DEFAULT + 1));
      return 7'd0;
   endfunction

   // Any byte but the terminator, for the body of a packet.
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      return (b == pabr_pkg::CR_BYTE) ? 8'h0A : b;
   endfunction

   // Pushes a body of the given length followed by a carriage return.
   task automatic push_packet(input int len);
      for (int i = 0; i < len; i++) send_word(pabr_pkg::OP_PUSH, body_byte(), 7'd1);
      send_word(pabr_pkg::OP_PUSH, pabr_pkg::CR_BYTE, 7'd1);
   endtask

   initial begin
      int r;
      int random_items;
      int len;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Pop and fetch on an empty ring, and the unused opcode.
      send_word(pabr_pkg::OP_POP, 8'h00, 7'd1);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd64);
      send_word(OP_UNUSED, 8'hFF, 7'd127);
      // Extreme byte values ending in a terminator. A fetch limit of zero takes
      // nothing, a limit of two cuts the packet, and an oversized limit is
      // clamped and returns the terminator, leaving the ring empty.
      send_word(pabr_pkg::OP_PUSH, 8'h00, 7'd1);
      send_word(pabr_pkg::OP_PUSH, 8'hFF, 7'd1);
      send_word(pabr_pkg::OP_PUSH, pabr_pkg::CR_BYTE, 7'd1);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd0);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd2);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd127);
      // A terminator taken out by a pop keeps the packet counted, so the next
      // fetch sees a packet count but an empty ring.
      send_word(pabr_pkg::OP_PUSH, pabr_pkg::CR_BYTE, 7'd1);
      send_word(pabr_pkg::OP_POP, 8'h00, 7'd1);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd1);
      // The count now runs ahead of the terminators held; a limit of one
      // stops before the terminator, the next fetch takes it.
      send_word(pabr_pkg::OP_PUSH, 8'h41, 7'd1);
      send_word(pabr_pkg::OP_PUSH, pabr_pkg::CR_BYTE, 7'd1);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd1);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd64);
      // A fetch that runs the ring empty before any terminator.
      send_word(pabr_pkg::OP_PUSH, 8'h55, 7'd1);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd64);
      send_word(pabr_pkg::OP_POP, 8'h00, 7'd1);
      send_word(OP_UNUSED, 8'h00, 7'd0);

      // Back-pressure: a long packet fetch meets a receiver that holds off,
      // while the sender keeps offering pushes until the block stops it.
      push_packet(25);
      hold_requests++;
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd64);
      for (int i = 0; i < 10; i++) send_word(pabr_pkg::OP_PUSH, body_byte(), 7'd1);
      drain_results();

      // A run of pushes with no idling on either side.
      steady_flow = 1'b1;
      for (int i = 0; i < FILL_ITEMS; i++)
         send_word(pabr_pkg::OP_PUSH,
                   (i % 23 == 22) ? pabr_pkg::CR_BYTE : body_byte(), 7'd1);
      steady_flow = 1'b0;
      for (int i = 0; i < 6; i++) send_word(pabr_pkg::OP_GET, 8'h00, pick_limit());

      // Random part: mostly whole packets followed by fetches, with loose
      // fetches, pops, stray pushes and the unused opcode as noise.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 55) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6);
            push_packet(len);
            random_items += len + 1;
            if ($urandom_range(99) < 75) begin
               send_word(pabr_pkg::OP_GET, 8'h00, pick_limit());
               random_items++;
            end
         end else if (r < 72) begin
            send_word(pabr_pkg::OP_GET, 8'h00, pick_limit());
            random_items++;
         end else if (r < 88) begin
            send_word(pabr_pkg::OP_POP, 8'($urandom_range(255)), 7'($urandom_range(127)));
            random_items++;
         end else if (r < 94) begin
            send_word(OP_UNUSED, 8'($urandom_range(255)), 7'($urandom_range(127)));
            random_items++;
         end else begin
            send_word(pabr_pkg::OP_PUSH, 8'($urandom_range(255)), 7'($urandom_range(127)));
            random_items++;
         end
         // Partway through, the sender waits for everything outstanding, and
         // a little later the receiver holds off once more.
         if (random_items >= 40 && random_items < 50) begin
            drain_results();
            random_items = 50;
         end else if (random_items >= 70 && random_items < 80) begin
            hold_requests++;
            random_items = 80;
         end
      end
      drain_results();

      send_word(pabr_pkg::OP_POP, 8'h00, 7'd1);
      send_word(pabr_pkg::OP_GET, 8'h00, 7'd0);

      // Wait for the last results, then keep watching in case the block
      // sends a word that nothing asked for.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d request words: %0d pushes, %0d pops, %0d fetches, %0d no-ops.",
               op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
               op_tally[pabr_pkg::OP_PUSH], op_tally[pabr_pkg::OP_POP],
               op_tally[pabr_pkg::OP_GET], op_tally[OP_UNUSED]);
      $display("Checked %0d result words, %0d bytes from the ring, %0d mismatches.",
               words_checked, ring_bytes_seen, fail_count);
      if (fail_count == 0) begin
         $display("tb_packet_aware_byte_ring_unit OK");
      end else begin
         $display("tb_packet_aware_byte_ring_unit NOT OK");
      end
      $finish;
   end

endmodule
